/* hw/rtl/bud_pkg.sv */
// ----------------------------------------------------------------------------
// bud_pkg
// Shared types, codes and helpers of the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bud_pkg;

  localparam int MAX_ORDER_LIMIT_DEF = 10;
  localparam int ORD_W = 5;   // holds any order up to the largest limit of 16
  localparam int KEY_W = 16;  // minimum-block index at the largest limit

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;

  localparam logic REG_MIN_BLOCK = 1'b0;
  localparam logic REG_ARENA     = 1'b1;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_REJECT,
    OP_IGNORE,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [ORD_W-1:0]   want;
    logic [KEY_W-1:0]   key;
  } op_t;

  typedef struct packed {
    logic [4:0]       m;
    logic [ORD_W-1:0] a;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [30:0] blk_bytes(input logic [4:0] m, input logic [ORD_W-1:0] o);
    logic [5:0] sh;
    sh = 6'(m) + 6'(o);
    return 31'(1) << sh;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bud_if.sv */
// ----------------------------------------------------------------------------
// bud_req_if / bud_rsp_if
// Request and response channels of the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bud_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] request_bytes;
  logic [29:0] block_offset;
  modport source (output valid, output command, output request_bytes,
                  output block_offset, input ready);
  modport sink   (input valid, input command, input request_bytes,
                  input block_offset, output ready);
endinterface

interface bud_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [29:0] granted_offset;
  logic [30:0] block_bytes;
  logic [30:0] free_bytes;
  logic [30:0] largest_free_bytes;
  modport source (output valid, output status, output granted_offset,
                  output block_bytes, output free_bytes, output largest_free_bytes,
                  input ready);
  modport sink   (input valid, input status, input granted_offset,
                  input block_bytes, input free_bytes, input largest_free_bytes,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/buddy_allocator.sv */
// Allocate scans bitmap words, then splits levels; free merges levels.
// Flow: one beat in flight in the sequencer; a two-entry queue and the
//   response register let the request side run ahead of a stalled consumer.
// Reset and any configuration write start a clearing pass over the bitmap and
//   live-order memories; requests wait meanwhile.
// ----------------------------------------------------------------------------
// buddy_allocator
// Buddy allocator top level: configuration registers, front, queue, back.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_allocator import bud_pkg::*; #(
  parameter int MAX_ORDER_LIMIT = MAX_ORDER_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bud_req_if.sink     request,
  bud_rsp_if.source   response,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]       min_block_log2;
  logic [3:0]       arena_order;
  logic             wr;
  logic [ORD_W-1:0] a_eff;
  logic [4:0]       m_lim;
  cfg_t             cfg;
  back_stat_t       stat;
  logic             push, pop, q_full, q_empty;
  op_t              op_in, op_out;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_block_log2 <= 5'd12;
      arena_order    <= 4'd10;
    end else if (wr) begin
      if (paddr[2] == REG_MIN_BLOCK) min_block_log2 <= pwdata[4:0];
      else                           arena_order    <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_ARENA) ? 32'(arena_order) : 32'(min_block_log2);

  assign a_eff = (ORD_W'(arena_order) > ORD_W'(MAX_ORDER_LIMIT)) ?
                 ORD_W'(MAX_ORDER_LIMIT) : ORD_W'(arena_order);
  assign m_lim = 5'd30 - 5'(a_eff);
  assign cfg.a = a_eff;
  assign cfg.m = (min_block_log2 > m_lim) ? m_lim : min_block_log2;

  bud_front u_front (
    .request (request),
    .cfg     (cfg),
    .stat    (stat),
    .q_full  (q_full),
    .push    (push),
    .op      (op_in)
  );

  bud_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (op_in),
    .full  (q_full),
    .pop   (pop),
    .dout  (op_out),
    .empty (q_empty)
  );

  bud_back #(.MAX_ORDER_LIMIT(MAX_ORDER_LIMIT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .init     (wr),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_op     (op_out),
    .pop      (pop),
    .stat     (stat),
    .response (response)
  );

endmodule

`default_nettype wire

/* hw/rtl/bud_front.sv */
// ----------------------------------------------------------------------------
// bud_front
// Takes request beats and classifies them: order wanted, block index, checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bud_front import bud_pkg::*; (
  bud_req_if.sink    request,
  input  cfg_t       cfg,
  input  back_stat_t stat,
  input  logic       q_full,
  output logic       push,
  output op_t        op
);

  logic [31:0] rm1;
  logic [5:0]  clog;
  logic [30:0] usable;
  logic [29:0] lowmask;
  logic [29:0] kfull;
  logic        aligned;
  logic        inrange;
  logic        is_live_cand;

  assign request.ready = !q_full && !stat.clearing;
  assign push = request.valid && request.ready;

  assign rm1 = request.request_bytes - 32'd1;

  // ceil(log2(bytes)) from the top set bit of bytes-1
  always_comb begin
    clog = '0;
    for (int b = 0; b < 32; b++) begin
      if (rm1[b]) clog = 6'(b + 1);
    end
  end

  assign usable  = blk_bytes(cfg.m, cfg.a);
  assign lowmask = (30'(1) << cfg.m) - 30'(1);
  assign aligned = (request.block_offset & lowmask) == '0;
  assign kfull   = request.block_offset >> cfg.m;
  assign inrange = (kfull >> cfg.a) == '0;
  assign is_live_cand = aligned && inrange;

  always_comb begin
    op.want = (clog > 6'(cfg.m)) ? ORD_W'(clog - 6'(cfg.m)) : '0;
    op.key  = KEY_W'(kfull);
    case (request.command)
      CMD_ALLOC: begin
        if (request.request_bytes == '0 || request.request_bytes > 32'(usable))
          op.kind = OP_REJECT;
        else
          op.kind = OP_ALLOC;
      end
      CMD_FREE:  op.kind = is_live_cand ? OP_FREE : OP_IGNORE;
      CMD_QUERY: op.kind = is_live_cand ? OP_QUERY : OP_NOP;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bud_fifo.sv */
// ----------------------------------------------------------------------------
// bud_fifo
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bud_fifo import bud_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  din,
  output logic full,
  input  logic pop,
  output op_t  dout,
  output logic empty
);

  op_t        mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bud_back.sv */
// ----------------------------------------------------------------------------
// bud_back
// Executes operations on the free bitmap and live-order memories, keeps the
// per-order free counts and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bud_back import bud_pkg::*; #(
  parameter int MAX_ORDER_LIMIT = MAX_ORDER_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       init,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  op_t        q_op,
  output logic       pop,
  output back_stat_t stat,
  bud_rsp_if.source  response
);

  localparam int L   = MAX_ORDER_LIMIT;
  localparam int BLK = 1 << L;
  localparam int OW  = $clog2(L + 1);
  localparam int LW  = $clog2(L + 2);
  localparam int CW  = L + 1;

  function automatic int order_words(input int o);
    return (L - o >= 5) ? (1 << (L - o - 5)) : 1;
  endfunction

  function automatic int total_words();
    int acc;
    acc = 0;
    for (int o = 0; o <= L; o++) acc += order_words(o);
    return acc;
  endfunction

  localparam int FREE_WORDS = total_words();
  localparam int FAW = $clog2(FREE_WORDS);

  function automatic logic [FAW-1:0] word_base(input logic [OW-1:0] o);
    int acc;
    acc = 0;
    for (int j = 0; j <= L; j++) begin
      if (j < int'(o)) acc += order_words(j);
    end
    return FAW'(acc);
  endfunction

  function automatic logic [FAW-1:0] waddr(input logic [OW-1:0] o, input logic [L-1:0] i);
    return word_base(o) + FAW'(i >> 5);
  endfunction

  function automatic logic [4:0] bitpos(input logic [L-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[4:0];
  endfunction

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_FIND, S_A_RD, S_A_CHK, S_SP_RD, S_SP_WR, S_A_LIVE,
    S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_Q_RD, S_Q_CHK, S_DONE
  } state_t;

  state_t state;

  logic [31:0]   free_mem [FREE_WORDS];
  logic [LW-1:0] live_mem [BLK];
  logic [31:0]   fdata;
  logic [LW-1:0] ldata;

  logic          f_we;
  logic [FAW-1:0] f_wa, f_ra;
  logic [31:0]   f_wd;
  logic          l_we;
  logic [L-1:0]  l_wa, l_ra;
  logic [LW-1:0] l_wd;

  logic [L-1:0]  clr;
  logic [OW-1:0] cur, want;
  logic [L-1:0]  idx, key;
  logic [CW-1:0] cnt [L+1];
  logic [30:0]   free_total;
  logic [1:0]    res_status;
  logic [29:0]   res_granted;
  logic [30:0]   res_bb;

  logic [OW-1:0] a_eff;
  logic          found_ok;
  logic [OW-1:0] found_o;
  logic          lg_ok;
  logic [OW-1:0] lg_o;
  logic [4:0]    lsb;
  logic [L-1:0]  split_idx;
  logic [L-1:0]  buddy;
  logic [L-1:0]  live_key;
  logic [OW-1:0] live_ord;
  logic [OW-1:0] free_ord;

  assign a_eff = OW'(cfg.a);
  assign stat.clearing = state == S_CLEAR;
  assign pop = state == S_IDLE && !q_empty && !init;

  // smallest order at or above the wanted one that has a free block
  always_comb begin
    found_ok = 1'b0;
    found_o  = '0;
    for (int o = L; o >= 0; o--) begin
      if (OW'(o) >= want && OW'(o) <= a_eff && cnt[o] != '0) begin
        found_ok = 1'b1;
        found_o  = OW'(o);
      end
    end
  end

  always_comb begin
    lg_ok = 1'b0;
    lg_o  = '0;
    for (int o = 0; o <= L; o++) begin
      if (cnt[o] != '0) begin
        lg_ok = 1'b1;
        lg_o  = OW'(o);
      end
    end
  end

  always_comb begin
    lsb = '0;
    for (int b = 31; b >= 0; b--) begin
      if (fdata[b]) lsb = 5'(b);
    end
  end

  assign split_idx = (idx << 1) | L'(1);
  assign buddy     = idx ^ L'(1);
  assign live_key  = idx << want;
  assign live_ord  = OW'(ldata - LW'(1));
  assign free_ord  = (live_ord > a_eff) ? a_eff : live_ord;

  // memory port selection
  always_comb begin
    f_we = 1'b0;
    f_wa = waddr(cur, idx);
    f_wd = fdata;
    f_ra = waddr(cur, idx);
    l_we = 1'b0;
    l_wa = key;
    l_wd = '0;
    l_ra = key;
    unique case (state)
      S_CLEAR: begin
        f_we = 32'(clr) < FREE_WORDS;
        f_wa = FAW'(clr);
        f_wd = (FAW'(clr) == word_base(a_eff)) ? 32'd1 : '0;
        l_we = 1'b1;
        l_wa = clr;
      end
      S_A_CHK: begin
        f_we = fdata != '0;
        f_wd = fdata & ~(32'(1) << lsb);
      end
      S_SP_RD: f_ra = waddr(cur - OW'(1), split_idx);
      S_SP_WR: begin
        f_we = 1'b1;
        f_wa = waddr(cur, idx | L'(1));
        f_wd = fdata | (32'(1) << bitpos(idx | L'(1)));
      end
      S_A_LIVE: begin
        l_we = 1'b1;
        l_wa = live_key;
        l_wd = LW'(want) + LW'(1);
      end
      S_F_CHK: l_we = ldata != '0;
      S_M_CHK: begin
        f_we = 1'b1;
        if (cur < a_eff && fdata[bitpos(buddy)])
          f_wd = fdata & ~(32'(1) << bitpos(buddy));
        else
          f_wd = fdata | (32'(1) << bitpos(idx));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) free_mem[f_wa] <= f_wd;
    fdata <= free_mem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) live_mem[l_wa] <= l_wd;
    ldata <= live_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr            <= '0;
      response.valid <= 1'b0;
    end else begin
      // a beat leaving in S_DONE is replaced there by the next one
      if (response.valid && response.ready && (init || state != S_DONE))
        response.valid <= 1'b0;
      if (init) begin
        state <= S_CLEAR;
        clr   <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr <= clr + L'(1);
            if (clr == '1) begin
              for (int o = 0; o <= L; o++) cnt[o] <= (OW'(o) == a_eff) ? CW'(1) : '0;
              free_total <= blk_bytes(cfg.m, ORD_W'(a_eff));
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (!q_empty) begin
              want        <= OW'(q_op.want);
              key         <= q_op.key[L-1:0];
              res_status  <= ST_OK;
              res_granted <= '0;
              res_bb      <= '0;
              case (q_op.kind)
                OP_ALLOC:  state <= S_A_FIND;
                OP_FREE:   state <= S_F_RD;
                OP_QUERY:  state <= S_Q_RD;
                OP_REJECT: begin
                  res_status <= ST_REJECT;
                  state      <= S_DONE;
                end
                OP_IGNORE: begin
                  res_status <= ST_NOT_LIVE;
                  state      <= S_DONE;
                end
                default:   state <= S_DONE;
              endcase
            end
          end
          S_A_FIND: begin
            if (found_ok) begin
              cur   <= found_o;
              idx   <= '0;
              state <= S_A_RD;
            end else begin
              res_status <= ST_REJECT;
              state      <= S_DONE;
            end
          end
          S_A_RD: state <= S_A_CHK;
          S_A_CHK: begin
            if (fdata == '0) begin
              idx   <= idx + L'(32);
              state <= S_A_RD;
            end else begin
              cnt[cur] <= cnt[cur] - CW'(1);
              idx      <= idx | L'(lsb);
              state    <= (cur > want) ? S_SP_RD : S_A_LIVE;
            end
          end
          S_SP_RD: begin
            cur   <= cur - OW'(1);
            idx   <= idx << 1;
            state <= S_SP_WR;
          end
          S_SP_WR: begin
            cnt[cur] <= cnt[cur] + CW'(1);
            state    <= (cur > want) ? S_SP_RD : S_A_LIVE;
          end
          S_A_LIVE: begin
            res_granted <= 30'(live_key) << cfg.m;
            res_bb      <= blk_bytes(cfg.m, ORD_W'(want));
            free_total  <= free_total - blk_bytes(cfg.m, ORD_W'(want));
            state       <= S_DONE;
          end
          S_F_RD: state <= S_F_CHK;
          S_F_CHK: begin
            if (ldata == '0) begin
              res_status <= ST_NOT_LIVE;
              state      <= S_DONE;
            end else begin
              cur        <= free_ord;
              idx        <= key >> free_ord;
              free_total <= free_total + blk_bytes(cfg.m, ORD_W'(free_ord));
              state      <= S_M_RD;
            end
          end
          S_M_RD: state <= S_M_CHK;
          S_M_CHK: begin
            // buddy free: absorb it and climb one order
            if (cur < a_eff && fdata[bitpos(buddy)]) begin
              cnt[cur] <= cnt[cur] - CW'(1);
              idx      <= idx >> 1;
              cur      <= cur + OW'(1);
              state    <= S_M_RD;
            end else begin
              cnt[cur] <= cnt[cur] + CW'(1);
              state    <= S_DONE;
            end
          end
          S_Q_RD: state <= S_Q_CHK;
          S_Q_CHK: begin
            if (ldata != '0) res_bb <= blk_bytes(cfg.m, ORD_W'(live_ord));
            state <= S_DONE;
          end
          S_DONE: begin
            if (!response.valid || response.ready) begin
              response.valid              <= 1'b1;
              response.status             <= res_status;
              response.granted_offset     <= res_granted;
              response.block_bytes        <= res_bb;
              response.free_bytes         <= free_total;
              response.largest_free_bytes <= lg_ok ? blk_bytes(cfg.m, ORD_W'(lg_o)) : '0;
              state                       <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bud_checker.sv */
// ----------------------------------------------------------------------------
// bud_checker
// Port-level checks of the buddy allocator response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bud_checker import bud_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  status,
  input logic [29:0] granted_offset,
  input logic [30:0] block_bytes,
  input logic [30:0] free_bytes,
  input logic [30:0] largest_free_bytes
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid) else $error("response beat dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    valid |-> status == ST_OK || status == ST_REJECT || status == ST_NOT_LIVE)
    else $error("undefined status code");

  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    valid && status != ST_OK |-> granted_offset == '0 && block_bytes == '0)
    else $error("offset or size on a failed beat");

  a_largest: assert property (@(posedge clk) disable iff (rst)
    valid |-> largest_free_bytes <= free_bytes)
    else $error("largest free block exceeds free total");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !valid) else $error("response valid straight after reset");

endmodule

bind buddy_allocator bud_checker u_bud_checker (
  .clk                (clk),
  .rst                (rst),
  .valid              (response.valid),
  .ready              (response.ready),
  .status             (response.status),
  .granted_offset     (response.granted_offset),
  .block_bytes        (response.block_bytes),
  .free_bytes         (response.free_bytes),
  .largest_free_bytes (response.largest_free_bytes)
);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed allocate, free and query beats into the buddy
// allocator, predicts each response with a behavioural model of the arena and
// compares every field. Configuration is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bud_pkg::*;

  localparam int MAXA = 10;
  localparam int NBLK = 1 << MAXA;

  typedef struct packed {
    logic [1:0]  status;
    logic [29:0] granted_offset;
    logic [30:0] block_bytes;
    logic [30:0] free_bytes;
    logic [30:0] largest_free_bytes;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bud_req_if req_ch();
  bud_rsp_if rsp_ch();

  buddy_allocator u_dut (
    .clk(clk), .rst(rst), .request(req_ch.sink), .response(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // arena model
  logic [4:0] reg_m;
  logic [3:0] reg_a;
  int unsigned em, ea;
  bit fmap [0:MAXA][0:NBLK-1];
  int unsigned lord [0:NBLK-1];
  int unsigned fcnt [0:MAXA];
  longint unsigned ftot;

  rsp_t pending_rsp[$];
  int mismatches = 0;
  int beats_sent = 0;
  int rsp_seen = 0;
  int grants = 0;
  longint unsigned live_offs[$];

  function automatic void arena_init();
    ea = (reg_a > MAXA) ? MAXA : reg_a;
    em = (reg_m > 30 - ea) ? 30 - ea : reg_m;
    for (int o = 0; o <= MAXA; o++) begin
      fcnt[o] = 0;
      for (int i = 0; i < NBLK; i++) fmap[o][i] = 0;
    end
    for (int i = 0; i < NBLK; i++) lord[i] = 0;
    fmap[ea][0] = 1;
    fcnt[ea] = 1;
    ftot = 64'd1 << (em + ea);
  endfunction

  function automatic int live_slot(longint unsigned off);
    longint unsigned k;
    if ((off & ((64'd1 << em) - 1)) != 0) return -1;
    k = off >> em;
    if (k >= (64'd1 << ea) || lord[k] == 0) return -1;
    return int'(k);
  endfunction

  function automatic rsp_t arena_step(logic [1:0] cmd, logic [31:0] req, logic [29:0] off);
    rsp_t r;
    longint unsigned st, gr, bb, usable, lf;
    int unsigned want, cur, idx, n, ord;
    int k;
    bit found;
    st = 0; gr = 0; bb = 0; found = 0; idx = 0;
    if (cmd == CMD_ALLOC) begin
      usable = 64'd1 << (em + ea);
      if (req == 0 || req > usable) st = ST_REJECT;
      else begin
        want = 0;
        while ((64'd1 << (em + want)) < req) want++;
        cur = want;
        while (cur <= ea && fcnt[cur] == 0) cur++;
        if (cur <= ea) begin
          n = 1 << (ea - cur);
          for (idx = 0; idx < n; idx++) if (fmap[cur][idx]) begin found = 1; break; end
        end
        if (!found) st = ST_REJECT;
        else begin
          fmap[cur][idx] = 0;
          fcnt[cur]--;
          while (cur > want) begin
            cur--;
            idx = idx << 1;
            fmap[cur][idx+1] = 1;
            fcnt[cur]++;
          end
          lord[(idx << want) & (NBLK-1)] = want + 1;
          gr = longint'(idx) << (em + want);
          bb = 64'd1 << (em + want);
          ftot -= bb;
        end
      end
    end else if (cmd == CMD_FREE) begin
      k = live_slot(off);
      if (k < 0) st = ST_NOT_LIVE;
      else begin
        ord = lord[k] - 1;
        if (ord > ea) ord = ea;
        idx = k >> ord;
        lord[k] = 0;
        ftot += 64'd1 << (em + ord);
        while (ord < ea && fmap[ord][idx ^ 1]) begin
          fmap[ord][idx ^ 1] = 0;
          fcnt[ord]--;
          idx = idx >> 1;
          ord++;
        end
        fmap[ord][idx] = 1;
        fcnt[ord]++;
      end
    end else if (cmd == CMD_QUERY) begin
      k = live_slot(off);
      if (k >= 0) bb = 64'd1 << (em + lord[k] - 1);
    end
    lf = 0;
    for (int o = ea; o >= 0; o--) if (fcnt[o] != 0) begin lf = 64'd1 << (em + o); break; end
    r.status = st[1:0];
    r.granted_offset = gr[29:0];
    r.block_bytes = bb[30:0];
    r.free_bytes = ftot[30:0];
    r.largest_free_bytes = lf[30:0];
    if (st == ST_OK && cmd == CMD_ALLOC) begin
      live_offs.push_back(gr);
      grants++;
    end
    return r;
  endfunction

  // request side
  initial begin
    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.request_bytes = '0;
    req_ch.block_offset = '0;
  end

  // valid stays up after a beat so that a back-to-back beat needs no second drive
  task automatic send_beat(logic [1:0] cmd, logic [31:0] req, logic [29:0] off);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.request_bytes <= req;
    req_ch.block_offset <= off;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_rsp.push_back(arena_step(cmd, req, off));
    beats_sent++;
    @(negedge clk);
  endtask

  // response side: random stall per beat
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.granted_offset = rsp_ch.granted_offset;
      got.block_bytes = rsp_ch.block_bytes;
      got.free_bytes = rsp_ch.free_bytes;
      got.largest_free_bytes = rsp_ch.largest_free_bytes;
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat %h", got);
      end else begin
        exp_r = pending_rsp.pop_front();
        if (got.status !== exp_r.status || got.granted_offset !== exp_r.granted_offset ||
            got.block_bytes !== exp_r.block_bytes || got.free_bytes !== exp_r.free_bytes ||
            got.largest_free_bytes !== exp_r.largest_free_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d off=%h blk=%0d free=%0d big=%0d",
                      " got st=%0d off=%h blk=%0d free=%0d big=%0d"},
                     exp_r.status, exp_r.granted_offset, exp_r.block_bytes, exp_r.free_bytes,
                     exp_r.largest_free_bytes, got.status, got.granted_offset, got.block_bytes,
                     got.free_bytes, got.largest_free_bytes);
        end
      end
    end
  end

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic apb_write(logic reg_sel, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= reg_sel == REG_ARENA ? 3'd4 : 3'd0;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == REG_ARENA) reg_a = val[3:0];
    else reg_m = val[4:0];
    arena_init();
    live_offs.delete();
  endtask

  task automatic set_config(logic [31:0] m, logic [31:0] a);
    drain();
    apb_write(REG_MIN_BLOCK, m);
    apb_write(REG_ARENA, a);
  endtask

  function automatic logic [29:0] pick_offset();
    longint unsigned o;
    if (live_offs.size() != 0 && $urandom_range(0, 9) < 7)
      o = live_offs[$urandom_range(0, live_offs.size() - 1)];
    else if ($urandom_range(0, 1)) o = longint'($urandom_range(0, NBLK)) << em;
    else o = {$urandom, $urandom};
    return o[29:0];
  endfunction

  function automatic logic [31:0] pick_bytes();
    int unsigned sh;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'd0;
      default: begin
        sh = em + $urandom_range(0, ea > 3 ? 3 : ea);
        return (32'd1 << sh) - $urandom_range(0, 1) * $urandom_range(0, (1 << sh) - 1);
      end
    endcase
  endfunction

  task automatic test_directed();
    send_beat(CMD_ALLOC, 32'd0, '0);                 // zero size
    send_beat(CMD_ALLOC, 32'hFFFF_FFFF, '0);         // oversize
    send_beat(CMD_ALLOC, 32'd1, '0);
    send_beat(CMD_ALLOC, 32'd4097, '0);
    send_beat(CMD_QUERY, '0, 30'h0);
    send_beat(CMD_QUERY, '0, 30'h2000);
    send_beat(CMD_QUERY, '0, 30'h1);                 // misaligned
    send_beat(CMD_FREE, '0, 30'h3FFF_FFFF);          // beyond arena
    send_beat(CMD_FREE, '0, 30'h0);
    send_beat(CMD_FREE, '0, 30'h0);                  // already freed
    send_beat(CMD_FREE, '0, 30'h2000);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    send_beat(CMD_ALLOC, 32'd1 << 22, '0);           // whole arena
    send_beat(CMD_ALLOC, 32'd1, '0);                 // no space left
    send_beat(CMD_FREE, '0, 30'h0);
    send_beat(CMD_QUERY, '0, 30'h2AAA_AAAA);
  endtask

  task automatic test_random(int count);
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: cmd = CMD_UNUSED;
        1, 2, 3, 4, 5, 6, 7, 8: cmd = CMD_ALLOC;
        9, 10, 11, 12, 13, 14, 15: cmd = CMD_FREE;
        default: cmd = CMD_QUERY;
      endcase
      send_beat(cmd, pick_bytes(), pick_offset());
    end
  endtask

  task automatic test_config_sweep();
    set_config(32'd0, 32'd0);
    test_random(40);
    set_config(32'd20, 32'd10);        // fills all 30 offset bits
    test_random(150);
    set_config(32'hFFFF_FFFF, 32'hF);  // out-of-range registers
    test_random(150);
    set_config(32'd0, 32'd3);
    test_random(200);
    set_config(32'd5, 32'd6);
    test_random(250);
    set_config(32'd12, 32'd10);
    test_random(350);
  endtask

  initial begin
    reg_m = 5'd12;
    reg_a = 4'd10;
    arena_init();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(60);
    test_config_sweep();
    drain();
    $display("covered %0d beats, %0d responses, %0d grants over seven configurations",
             beats_sent, rsp_seen, grants);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d outstanding", mismatches, pending_rsp.size());
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end

endmodule

/* buddy_allocator.f */
hw/rtl/bud_pkg.sv
hw/rtl/bud_if.sv
hw/rtl/bud_front.sv
hw/rtl/bud_fifo.sv
hw/rtl/bud_back.sv
hw/rtl/buddy_allocator.sv
hw/rtl/bud_checker.sv
sim/testbench.sv
